/* sv/lirs_pkg.sv */
package lirs_pkg;

    // sample and lane geometry
    localparam int N_LANES    = 4;
    localparam int SAMPLE_W   = 24;
    localparam int FRAME_W    = N_LANES * SAMPLE_W;

    // phase accumulator, fixed point with FRAC_BITS fraction bits
    localparam int FRAC_BITS  = 16;
    localparam int PHASE_W    = 32;
    localparam int STEP_W     = 20;
    localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 3);

    // buffer geometry
    localparam int MAX_BUFFER_FRAMES = 4096;
    localparam int POS_W      = $clog2(MAX_BUFFER_FRAMES);
    localparam int COUNT_W    = POS_W + 1;

    // per-input output limit
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = $clog2(MAX_RESULTS) + 1;

    // configuration port
    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_CHANNELS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_FRAMES = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [N_LANES-1:0] frame_t;

    // one classified source frame waiting for the back end
    typedef struct packed {
        frame_t             samples;
        logic               last;
        logic [POS_W-1:0]   pos;
    } item_t;

    // effective settings after clamping
    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] cap;
        logic [CH_W-1:0]    lanes;
    } cfg_t;

    // one output request from the sequencer to the datapath
    typedef struct packed {
        logic                 valid;
        logic                 copy;
        logic [FRAC_BITS-1:0] frac;
        logic [POS_W-1:0]     index;
        logic                 run_last;
    } issue_t;

endpackage

/* sv/lirs_front.sv */
module lirs_front
    import lirs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [FRAME_W-1:0] s_tdata,
    input  logic               s_tlast,
    output logic               push_valid,
    input  logic               push_ready,
    output item_t              push_item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             frame_last;

    // a frame at the last buffer slot closes the buffer on its own
    assign frame_last = s_tlast || (pos_reg == POS_W'(MAX_BUFFER_FRAMES - 1));

    assign s_tready             = push_ready;
    assign push_valid           = s_tvalid;
    assign push_item.samples    = frame_t'(s_tdata);
    assign push_item.last       = frame_last;
    assign push_item.pos        = pos_reg;

    // position of the next frame within its buffer
    always_comb begin
        pos_next = pos_reg;
        if (s_tvalid && push_ready) begin
            pos_next = frame_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* sv/lirs_fifo.sv */
module lirs_fifo
    import lirs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  head_valid,
    output item_t head_item,
    input  logic  pop
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/lirs_seq.sv */
module lirs_seq
    import lirs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   head_valid,
    input  item_t  head_item,
    output logic   pop,
    output issue_t issue,
    input  logic   issue_ready,
    output frame_t prev_frame
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     n_next;
    logic               seg_reg;
    logic               seg_next;
    frame_t             prev_reg;
    frame_t             prev_next;

    logic [POS_W:0]     pos_inc;
    logic [PHASE_W-1:0] bound0;
    logic [PHASE_W-1:0] bound1;
    logic [PHASE_W-1:0] phase_inc;
    logic [COUNT_W-1:0] count_inc;
    logic [N_W-1:0]     n_inc;
    logic               first0;
    logic               first1;
    logic               next0;
    logic               next1;
    logic               fire;

    function automatic logic can_emit(
        input logic [PHASE_W-1:0] phase,
        input logic [N_W-1:0]     n,
        input logic [COUNT_W-1:0] count,
        input logic [COUNT_W-1:0] cap,
        input logic [PHASE_W-1:0] bound
    );
        can_emit = (n < N_W'(MAX_RESULTS)) && (count < cap) && (phase < bound);
    endfunction

    // segment bounds: interpolation up to pos, copies up to pos+1
    assign pos_inc = {1'b0, head_item.pos} + (POS_W+1)'(1);
    assign bound0  = {{(PHASE_W-POS_W-FRAC_BITS){1'b0}}, head_item.pos, {FRAC_BITS{1'b0}}};
    assign bound1  = {{(PHASE_W-POS_W-1-FRAC_BITS){1'b0}}, pos_inc, {FRAC_BITS{1'b0}}};

    assign phase_inc = phase_reg + PHASE_W'(cfg.step);
    assign count_inc = count_reg + COUNT_W'(1);
    assign n_inc     = n_reg + N_W'(1);

    // first output of an item, and lookahead for the one after the current
    assign first0 = (head_item.pos != '0) && can_emit(phase_reg, n_reg, count_reg, cfg.cap, bound0);
    assign first1 = head_item.last && can_emit(phase_reg, n_reg, count_reg, cfg.cap, bound1);
    assign next0  = !seg_reg && (head_item.pos != '0)
                    && can_emit(phase_inc, n_inc, count_inc, cfg.cap, bound0);
    assign next1  = head_item.last && can_emit(phase_inc, n_inc, count_inc, cfg.cap, bound1);

    assign fire = (state_reg == ST_RUN) && issue_ready;

    assign issue.valid    = (state_reg == ST_RUN);
    assign issue.copy     = seg_reg;
    assign issue.frac     = phase_reg[FRAC_BITS-1:0];
    assign issue.index    = count_reg[POS_W-1:0];
    assign issue.run_last = !(next0 || next1);

    assign prev_frame = prev_reg;

    // item sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        n_next     = n_reg;
        seg_next   = seg_reg;
        prev_next  = prev_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    if (first0) begin
                        seg_next   = 1'b0;
                        state_next = ST_RUN;
                    end else if (first1) begin
                        seg_next   = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                if (fire) begin
                    phase_next = phase_inc;
                    count_next = count_inc;
                    n_next     = n_inc;
                    seg_next   = !next0;
                    state_next = (next0 || next1) ? ST_RUN : ST_DONE;
                end
            end
            ST_DONE: begin
                // buffer end: rebase the phase to the next buffer
                if (head_item.last) begin
                    phase_next = (phase_reg > bound1) ? phase_reg - bound1 : '0;
                    count_next = '0;
                end
                n_next     = '0;
                prev_next  = head_item.samples;
                pop        = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            count_reg <= '0;
            n_reg     <= '0;
            seg_reg   <= 1'b0;
            prev_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            seg_reg   <= seg_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

/* sv/lirs_interp.sv */
module lirs_interp
    import lirs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  issue_t             issue,
    output logic               issue_ready,
    input  frame_t             prev_frame,
    input  frame_t             cur_frame,
    input  logic [CH_W-1:0]    lanes,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [FRAME_W-1:0] m_tdata,
    output logic [POS_W-1:0]   m_tuser,
    output logic               m_tlast
);

    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic signed [PROD_W-1:0] prod_reg [N_LANES];
    logic signed [PROD_W-1:0] prod_next [N_LANES];
    sample_t                  base_reg [N_LANES];
    sample_t                  base_next [N_LANES];
    logic [POS_W-1:0]         s1_index_reg;
    logic                     s1_last_reg;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    frame_t                   m_data_reg;
    frame_t                   m_data_next;
    logic [POS_W-1:0]         m_index_reg;
    logic                     m_last_reg;

    logic                     s1_ready;
    logic                     s2_ready;
    logic                     s1_load;
    logic                     s2_load;

    assign s2_ready    = !m_valid_reg || m_tready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign issue_ready = s1_ready;
    assign s1_load     = issue.valid && s1_ready;
    assign s2_load     = s1_valid_reg && s2_ready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_index_reg;
    assign m_tlast  = m_last_reg;

    // stage 1: lane difference times fraction, inactive lanes forced to zero
    always_comb begin
        logic signed [SAMPLE_W:0]  diff;
        logic signed [FRAC_BITS:0] frac_s;
        sample_t                   s0;
        frac_s = $signed({1'b0, issue.frac});
        for (int c = 0; c < N_LANES; c++) begin
            s0 = issue.copy ? cur_frame[c] : prev_frame[c];
            if (CH_W'(c) < lanes) begin
                diff         = $signed({cur_frame[c][SAMPLE_W-1], cur_frame[c]})
                               - $signed({s0[SAMPLE_W-1], s0});
                base_next[c] = s0;
            end else begin
                diff         = '0;
                base_next[c] = '0;
            end
            prod_next[c] = PROD_W'(diff) * PROD_W'(frac_s);
        end
    end

    // stage 2: round to nearest, ties up, then add the base sample
    always_comb begin
        logic signed [PROD_W-1:0]   rnd_full;
        logic signed [SAMPLE_W+1:0] sum;
        for (int c = 0; c < N_LANES; c++) begin
            rnd_full       = (prod_reg[c] + RND) >>> FRAC_BITS;
            sum            = $signed({{2{base_reg[c][SAMPLE_W-1]}}, base_reg[c]})
                             + $signed(rnd_full[SAMPLE_W+1:0]);
            m_data_next[c] = sum[SAMPLE_W-1:0];
        end
    end

    // stage valid flags
    always_comb begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s1_ready) begin
            s1_valid_next = issue.valid;
        end
        if (s2_ready) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            prod_reg     <= prod_next;
            base_reg     <= base_next;
            s1_index_reg <= issue.index;
            s1_last_reg  <= issue.run_last;
        end
        if (s2_load) begin
            m_data_reg  <= m_data_next;
            m_index_reg <= s1_index_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

endmodule

/* sv/linear_interp_resampler_core.sv */
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  tdata: sample_a..sample_d, tlast: buffer_end
// m_       out        m_tvalid/m_tready  tdata: out_a..out_d, tuser: frame_index, tlast: run_last
// cfg_     in         cfg_valid/cfg_ready cfg_index: register, cfg_data: value
//
// a source frame passes the sequencer through IDLE, RUN per output (0..16) and DONE;
// outputs leave a two-stage multiply and round datapath one per cycle while m_tready is high
// a two-entry queue holds classified frames, so input is taken while the sequencer works
// aresetn is synchronous, active low; it restores the register defaults and clears control state
// a stalled m_tready holds the datapath, then the sequencer, then the queue and s_tready
// cfg_ready is always high; write registers only while the block is idle
module linear_interp_resampler_core
    import lirs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FRAME_W-1:0]    s_tdata,   // sample_a, sample_b, sample_c, sample_d
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [FRAME_W-1:0]    m_tdata,   // out_a, out_b, out_c, out_d
    output logic [POS_W-1:0]      m_tuser,   // frame_index
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [STEP_W-1:0]  phase_step_reg;
    logic [STEP_W-1:0]  phase_step_next;
    logic [CH_W-1:0]    src_channels_reg;
    logic [CH_W-1:0]    src_channels_next;
    logic [CH_W-1:0]    dst_channels_reg;
    logic [CH_W-1:0]    dst_channels_next;
    logic [COUNT_W-1:0] max_out_reg;
    logic [COUNT_W-1:0] max_out_next;

    cfg_t               cfg;
    logic [CH_W-1:0]    ch_min;
    logic               push_valid;
    logic               push_ready;
    item_t              push_item;
    logic               head_valid;
    item_t              head_item;
    logic               pop;
    issue_t             issue;
    logic               issue_ready;
    frame_t             prev_frame;

    assign cfg_ready = 1'b1;

    // register writes
    always_comb begin
        phase_step_next   = phase_step_reg;
        src_channels_next = src_channels_reg;
        dst_channels_next = dst_channels_reg;
        max_out_next      = max_out_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PHASE_STEP:     phase_step_next   = cfg_data[STEP_W-1:0];
                REG_SRC_CHANNELS:   src_channels_next = cfg_data[CH_W-1:0];
                REG_DST_CHANNELS:   dst_channels_next = cfg_data[CH_W-1:0];
                REG_MAX_OUT_FRAMES: max_out_next      = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= STEP_W'(65536);
            src_channels_reg <= CH_W'(2);
            dst_channels_reg <= CH_W'(2);
            max_out_reg      <= COUNT_W'(MAX_BUFFER_FRAMES);
        end else begin
            phase_step_reg   <= phase_step_next;
            src_channels_reg <= src_channels_next;
            dst_channels_reg <= dst_channels_next;
            max_out_reg      <= max_out_next;
        end
    end

    // clamp settings to the supported range
    assign ch_min    = (src_channels_reg < dst_channels_reg) ? src_channels_reg : dst_channels_reg;
    assign cfg.lanes = (ch_min > CH_W'(N_LANES)) ? CH_W'(N_LANES) : ch_min;
    assign cfg.step  = (phase_step_reg < MIN_STEP) ? MIN_STEP : phase_step_reg;
    assign cfg.cap   = (max_out_reg > COUNT_W'(MAX_BUFFER_FRAMES))
                       ? COUNT_W'(MAX_BUFFER_FRAMES) : max_out_reg;

    lirs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lirs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    lirs_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .issue       (issue),
        .issue_ready (issue_ready),
        .prev_frame  (prev_frame)
    );

    lirs_interp u_interp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .issue_ready (issue_ready),
        .prev_frame  (prev_frame),
        .cur_frame   (head_item.samples),
        .lanes       (cfg.lanes),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* sv/lirs_check.sv */
module lirs_check
    import lirs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [FRAME_W-1:0]    m_tdata,
    input logic [POS_W-1:0]      m_tuser,
    input logic                  m_tlast
);

    logic             in_acc;
    logic             out_acc;
    logic             prev_last_reg;
    logic             prev_last_next;
    logic [POS_W-1:0] prev_idx_reg;
    logic [POS_W-1:0] prev_idx_next;
    logic [N_W-1:0]   run_cnt_reg;
    logic [N_W-1:0]   run_cnt_next;
    logic [15:0]      pend_reg;
    logic [15:0]      pend_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // track the output run and the inputs not yet closed by a last output
    always_comb begin
        prev_last_next = prev_last_reg;
        prev_idx_next  = prev_idx_reg;
        run_cnt_next   = run_cnt_reg;
        pend_next      = pend_reg;
        if (out_acc) begin
            prev_last_next = m_tlast;
            prev_idx_next  = m_tuser;
            run_cnt_next   = m_tlast ? '0 : run_cnt_reg + N_W'(1);
        end
        if (in_acc && !(out_acc && m_tlast)) begin
            pend_next = (pend_reg == 16'hFFFF) ? pend_reg : pend_reg + 16'd1;
        end else if (!in_acc && out_acc && m_tlast
                     && pend_reg != 16'hFFFF && pend_reg != 16'd0) begin
            pend_next = pend_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_last_reg <= 1'b1;
            prev_idx_reg  <= '0;
            run_cnt_reg   <= '0;
            pend_reg      <= '0;
        end else begin
            prev_last_reg <= prev_last_next;
            prev_idx_reg  <= prev_idx_next;
            run_cnt_reg   <= run_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    // a stalled result holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // outputs of one run carry consecutive frame indexes
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !prev_last_reg |-> m_tuser == POS_W'(prev_idx_reg + POS_W'(1)))
        else $error("frame index not consecutive within a run");

    // no input causes more than sixteen outputs
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && run_cnt_reg == N_W'(MAX_RESULTS - 1) |-> m_tlast)
        else $error("run longer than the output limit");

    // every closed run belongs to an earlier input
    a_run_src: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_tlast |-> pend_reg != 16'd0)
        else $error("run closed with no input outstanding");

endmodule

bind linear_interp_resampler_core lirs_check u_lirs_check (.*);
